/* design/dtq_pkg.sv */
// deadline timer queue: shared constants, codes and control structs
// no dependencies
package dtq_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 48;
  localparam int unsigned MAX_RESULTS   = 16;
  localparam int unsigned NF_W          = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [2:0] KIND_ADDED  = 3'd0;
  localparam logic [2:0] KIND_CANCEL = 3'd1;
  localparam logic [2:0] KIND_MISS   = 3'd2;
  localparam logic [2:0] KIND_FIRED  = 3'd3;
  localparam logic [2:0] KIND_NONE   = 3'd4;
  localparam logic [2:0] KIND_FULL   = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_MARK,
    OP_DROP,
    OP_TAKE
  } op_e;

  typedef enum logic [2:0] {
    OS_NONE,
    OS_ADDED,
    OS_FULL,
    OS_CANCEL,
    OS_MISS,
    OS_FIRED,
    OS_IDLE
  } osel_e;

  typedef struct packed {
    logic  load;
    logic  scan_start;
    logic  fill;
    op_e   op;
    osel_e out_sel;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       scan_done;
    logic       free_found;
    logic       hit_found;
    logic       expired;
    logic       best_stopped;
    logic       held_v;
  } sts_t;

endpackage

/* design/dtq_if.sv */
// deadline timer queue: request and result channel interfaces
// depends on nothing
interface dtq_in_if #(parameter int unsigned TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [TIME_BITS-1:0] now_time;
  logic [31:0]          delay;
  logic [31:0]          cancel_seq;
  modport source (output valid, req_type, now_time, delay, cancel_seq, input ready);
  modport sink   (input valid, req_type, now_time, delay, cancel_seq, output ready);
endinterface

interface dtq_out_if #(parameter int unsigned TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic [2:0]           result_kind;
  logic [31:0]          seq_num;
  logic [TIME_BITS-1:0] deadline;
  logic [TIME_BITS-1:0] next_deadline;
  logic                 armed;
  logic                 last;
  modport source (output valid, result_kind, seq_num, deadline, next_deadline, armed, last,
                  input ready);
  modport sink   (input valid, result_kind, seq_num, deadline, next_deadline, armed, last,
                  output ready);
endinterface

/* design/dtq_datapath.sv */
// deadline timer queue datapath: slot store, scan unit, held result, output word
// depends on dtq_pkg
module dtq_datapath #(
  parameter int unsigned DEPTH     = dtq_pkg::DEPTH_DEF,
  parameter int unsigned TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtq_pkg::cmd_t        cmd_i,
  output dtq_pkg::sts_t        sts_o,
  input  logic [1:0]           req_type_i,
  input  logic [TIME_BITS-1:0] now_time_i,
  input  logic [31:0]          delay_i,
  input  logic [31:0]          cancel_seq_i,
  output logic [2:0]           result_kind_o,
  output logic [31:0]          seq_num_o,
  output logic [TIME_BITS-1:0] deadline_o,
  output logic [TIME_BITS-1:0] next_deadline_o,
  output logic                 armed_o,
  output logic                 last_o
);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  logic [TIME_BITS-1:0] mem_dl  [DEPTH];
  logic [31:0]          mem_seq [DEPTH];
  logic [TIME_BITS-1:0] rd_dl_q;
  logic [31:0]          rd_seq_q;

  logic [DEPTH-1:0] valid_q, stopped_q;
  logic [1:0]       req_q;
  logic [TIME_BITS-1:0] now_q, add_dl_q;
  logic [31:0]      cseq_q, next_seq_q;

  logic          run_q, chk_v_q, chk_last_q;
  logic [IW-1:0] idx_q, chk_idx_q;

  logic                 free_q, hit_q, best_q;
  logic [IW-1:0]        free_idx_q, hit_idx_q, best_idx_q;
  logic [TIME_BITS-1:0] hit_dl_q, best_dl_q;
  logic [31:0]          best_seq_q;

  logic                 held_v_q, held_pend_q, held_armed_q;
  logic [31:0]          held_seq_q;
  logic [TIME_BITS-1:0] held_dl_q, held_nd_q;
  logic [dtq_pkg::NF_W-1:0] nfired_q;

  // saturating deadline of an add
  logic [SW-1:0]        sum;
  logic [SW-1:0]        tmax;
  logic [TIME_BITS-1:0] add_dl;
  assign sum    = SW'(now_time_i) + SW'(delay_i);
  assign tmax   = {{(SW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
  assign add_dl = (sum > tmax) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  logic                 cur_v, better;
  logic [TIME_BITS-1:0] best_nd, held_nd;
  logic                 held_armed;
  assign cur_v   = valid_q[chk_idx_q];
  assign better  = !best_q || (rd_dl_q < best_dl_q) ||
                   ((rd_dl_q == best_dl_q) && (rd_seq_q < best_seq_q));
  assign best_nd = best_q ? best_dl_q : '0;
  assign held_nd    = held_pend_q ? best_nd : held_nd_q;
  assign held_armed = held_pend_q ? best_q : held_armed_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dtq_pkg::OP_WRITE) begin
      mem_dl[free_idx_q]  <= add_dl_q;
      mem_seq[free_idx_q] <= next_seq_q;
    end
    rd_dl_q  <= mem_dl[idx_q];
    rd_seq_q <= mem_seq[idx_q];
  end

  // request capture, result payload and scan accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      now_q    <= now_time_i;
      add_dl_q <= add_dl;
      cseq_q   <= cancel_seq_i;
    end
    chk_idx_q <= idx_q;
    if (cmd_i.scan_start) begin
      free_q <= 1'b0;
      hit_q  <= 1'b0;
      best_q <= 1'b0;
    end else if (chk_v_q) begin
      if (!cur_v && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= chk_idx_q;
      end
      if (cur_v && !hit_q && (rd_seq_q == cseq_q)) begin
        hit_q     <= 1'b1;
        hit_idx_q <= chk_idx_q;
        hit_dl_q  <= rd_dl_q;
      end
      if (cur_v && better) begin
        best_q     <= 1'b1;
        best_idx_q <= chk_idx_q;
        best_dl_q  <= rd_dl_q;
        best_seq_q <= rd_seq_q;
      end
    end
    if (cmd_i.fill && held_pend_q) begin
      held_nd_q    <= best_nd;
      held_armed_q <= best_q;
    end
    if (cmd_i.op == dtq_pkg::OP_TAKE) begin
      held_seq_q <= best_seq_q;
      held_dl_q  <= best_dl_q;
    end
    case (cmd_i.out_sel)
      dtq_pkg::OS_ADDED: begin
        result_kind_o   <= dtq_pkg::KIND_ADDED;
        seq_num_o       <= next_seq_q;
        deadline_o      <= add_dl_q;
        next_deadline_o <= (best_q && (best_dl_q < add_dl_q)) ? best_dl_q : add_dl_q;
        armed_o         <= 1'b1;
      end
      dtq_pkg::OS_FULL: begin
        result_kind_o   <= dtq_pkg::KIND_FULL;
        seq_num_o       <= '0;
        deadline_o      <= '0;
        next_deadline_o <= best_nd;
        armed_o         <= best_q;
      end
      dtq_pkg::OS_CANCEL: begin
        result_kind_o   <= dtq_pkg::KIND_CANCEL;
        seq_num_o       <= cseq_q;
        deadline_o      <= hit_dl_q;
        next_deadline_o <= best_nd;
        armed_o         <= best_q;
      end
      dtq_pkg::OS_MISS: begin
        result_kind_o   <= dtq_pkg::KIND_MISS;
        seq_num_o       <= cseq_q;
        deadline_o      <= '0;
        next_deadline_o <= best_nd;
        armed_o         <= best_q;
      end
      dtq_pkg::OS_FIRED: begin
        result_kind_o   <= dtq_pkg::KIND_FIRED;
        seq_num_o       <= held_seq_q;
        deadline_o      <= held_dl_q;
        next_deadline_o <= held_nd;
        armed_o         <= held_armed;
      end
      dtq_pkg::OS_IDLE: begin
        result_kind_o   <= dtq_pkg::KIND_NONE;
        seq_num_o       <= '0;
        deadline_o      <= '0;
        next_deadline_o <= best_nd;
        armed_o         <= best_q;
      end
      default: ;
    endcase
    if (cmd_i.out_sel != dtq_pkg::OS_NONE) begin
      last_o <= cmd_i.out_last;
    end
  end

  // control state: slot flags, sequence counter, scan pointer, held flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      stopped_q   <= '0;
      next_seq_q  <= '0;
      run_q       <= 1'b0;
      chk_v_q     <= 1'b0;
      chk_last_q  <= 1'b0;
      idx_q       <= '0;
      held_v_q    <= 1'b0;
      held_pend_q <= 1'b0;
      nfired_q    <= '0;
    end else begin
      chk_v_q    <= run_q;
      chk_last_q <= run_q && (idx_q == LAST_IDX);
      if (cmd_i.scan_start) begin
        run_q <= 1'b1;
        idx_q <= '0;
      end else if (run_q) begin
        if (idx_q == LAST_IDX) begin
          run_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.load) begin
        held_v_q    <= 1'b0;
        held_pend_q <= 1'b0;
        nfired_q    <= '0;
      end
      // a take in the same step starts a new pending word instead
      if (cmd_i.fill && (cmd_i.op != dtq_pkg::OP_TAKE)) begin
        held_pend_q <= 1'b0;
      end
      case (cmd_i.op)
        dtq_pkg::OP_WRITE: begin
          valid_q[free_idx_q]   <= 1'b1;
          stopped_q[free_idx_q] <= 1'b0;
          next_seq_q            <= next_seq_q + 32'd1;
        end
        dtq_pkg::OP_MARK: stopped_q[hit_idx_q] <= 1'b1;
        dtq_pkg::OP_DROP: valid_q[best_idx_q] <= 1'b0;
        dtq_pkg::OP_TAKE: begin
          valid_q[best_idx_q] <= 1'b0;
          held_v_q            <= 1'b1;
          held_pend_q         <= 1'b1;
          nfired_q            <= nfired_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.req_type     = req_q;
  assign sts_o.scan_done    = chk_v_q && chk_last_q;
  assign sts_o.free_found   = free_q;
  assign sts_o.hit_found    = hit_q;
  assign sts_o.expired      = best_q && (best_dl_q <= now_q) &&
                              (nfired_q != dtq_pkg::NF_W'(dtq_pkg::MAX_RESULTS));
  assign sts_o.best_stopped = stopped_q[best_idx_q];
  assign sts_o.held_v       = held_v_q;
endmodule

/* design/dtq_ctrl.sv */
// deadline timer queue controller: request sequencing and output handshake
// depends on dtq_pkg
module dtq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dtq_pkg::sts_t sts_i,
  output dtq_pkg::cmd_t cmd_o
);
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_OUT    = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   again_q, again_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    again_d     = again_q;
    out_valid_d = out_valid_q;
    cmd_o       = '{load: 1'b0, scan_start: 1'b0, fill: 1'b0, op: dtq_pkg::OP_NONE,
                    out_sel: dtq_pkg::OS_NONE, out_last: 1'b1};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_OUT;
        again_d = 1'b0;
        case (sts_i.req_type)
          dtq_pkg::REQ_ADD: begin
            if (sts_i.free_found) begin
              cmd_o.op      = dtq_pkg::OP_WRITE;
              cmd_o.out_sel = dtq_pkg::OS_ADDED;
            end else begin
              cmd_o.out_sel = dtq_pkg::OS_FULL;
            end
          end
          dtq_pkg::REQ_CANCEL: begin
            if (sts_i.hit_found) begin
              cmd_o.op      = dtq_pkg::OP_MARK;
              cmd_o.out_sel = dtq_pkg::OS_CANCEL;
            end else begin
              cmd_o.out_sel = dtq_pkg::OS_MISS;
            end
          end
          dtq_pkg::REQ_TICK: begin
            cmd_o.fill = 1'b1;
            if (sts_i.expired && sts_i.best_stopped) begin
              cmd_o.op         = dtq_pkg::OP_DROP;
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end else if (sts_i.expired) begin
              cmd_o.op = dtq_pkg::OP_TAKE;
              if (sts_i.held_v) begin
                cmd_o.out_sel  = dtq_pkg::OS_FIRED;
                cmd_o.out_last = 1'b0;
                again_d        = 1'b1;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = ST_SCAN;
              end
            end else if (sts_i.held_v) begin
              cmd_o.out_sel = dtq_pkg::OS_FIRED;
            end else begin
              cmd_o.out_sel = dtq_pkg::OS_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
        if (state_d == ST_OUT) begin
          out_valid_d = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (again_q) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      again_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      again_q     <= again_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

/* design/deadline_timer_queue_core.sv */
// deadline timer queue top level: controller plus datapath
// depends on dtq_pkg, dtq_if, dtq_ctrl, dtq_datapath
//
// usage
//  - req_i takes one request word (add, cancel, tick) at a time; ready is high
//    only while the block is idle
//  - rsp_o gives result words; a tick may give up to MAX_RESULTS fired words,
//    the final word of every request has last set
//  - every request starts with a scan of all DEPTH slots, one slot a cycle
//    through the registered slot memory read
//  - add and cancel: the word is registered in the decide state after the scan;
//    the next request is taken once the word is accepted and the block is idle
//  - tick: one scan per removed timer plus the first scan, and the output
//    handshakes of the fired words
//  - a request of unknown type gives no word and returns to idle
//  - reset clears all slot valid and stopped flags and the sequence counter;
//    slot contents stay undefined until written, no clearing pass is needed
//  - when the receiver stalls, the result word is held stable in the output
//    register and all work waits on it
module deadline_timer_queue_core #(
  parameter int unsigned DEPTH     = dtq_pkg::DEPTH_DEF,
  parameter int unsigned TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtq_in_if.sink     req_i,
  dtq_out_if.source  rsp_o
);
  dtq_pkg::cmd_t cmd;
  dtq_pkg::sts_t sts;

  // sequencing of scans, slot updates and result words
  dtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // slot store, scan accumulators and the output word register
  dtq_datapath #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_i.req_type),
    .now_time_i      (req_i.now_time),
    .delay_i         (req_i.delay),
    .cancel_seq_i    (req_i.cancel_seq),
    .result_kind_o   (rsp_o.result_kind),
    .seq_num_o       (rsp_o.seq_num),
    .deadline_o      (rsp_o.deadline),
    .next_deadline_o (rsp_o.next_deadline),
    .armed_o         (rsp_o.armed),
    .last_o          (rsp_o.last)
  );
endmodule

/* sim/dtq_checker.sv */
// deadline timer queue checker: watches request and result channels,
// predicts result words and compares them; depends on dtq_pkg and dtq_if
module dtq_checker #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtq_in_if.sink      req_w,
  dtq_out_if.sink     rsp_w,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);
  import dtq_pkg::*;

  typedef struct packed {
    logic [2:0]           kind;
    logic [31:0]          seq;
    logic [TIME_BITS-1:0] dl;
    logic [TIME_BITS-1:0] next_dl;
    logic                 armed;
    logic                 last;
  } rsp_t;

  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [TIME_BITS-1:0] tq_dl [DEPTH];
  logic [31:0]          tq_seq [DEPTH];
  logic                 tq_stop [DEPTH];
  logic                 tq_vld [DEPTH];
  logic [31:0]          seq_ctr;
  rsp_t                 result_q [$];
  int unsigned          fails;

  assign fail_cnt_o = fails;
  assign pending_o  = result_q.size();

  function automatic int earliest_timer();
    int b;
    b = -1;
    for (int i = 0; i < DEPTH; i++)
      if (tq_vld[i] && (b < 0 || tq_dl[i] < tq_dl[b] ||
          (tq_dl[i] == tq_dl[b] && tq_seq[i] < tq_seq[b]))) b = i;
    return b;
  endfunction

  function automatic void push_result(logic [2:0] k, logic [31:0] s, logic [TIME_BITS-1:0] d);
    rsp_t r;
    int e;
    e = earliest_timer();
    r.kind = k; r.seq = s; r.dl = d;
    r.next_dl = (e >= 0) ? tq_dl[e] : '0;
    r.armed = (e >= 0);
    r.last = 1'b0;
    result_q.push_back(r);
  endfunction

  task automatic predict_request(logic [1:0] rt, logic [TIME_BITS-1:0] now,
                                 logic [31:0] dly, logic [31:0] cs);
    int slot, n, e;
    logic [TIME_BITS:0] sum;
    slot = -1; n = 0;
    case (rt)
      REQ_ADD: begin
        for (int i = 0; i < DEPTH; i++) if (!tq_vld[i] && slot < 0) slot = i;
        if (slot < 0) begin
          push_result(KIND_FULL, '0, '0);
        end else begin
          sum = {1'b0, now} + dly;
          tq_dl[slot] = sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
          tq_seq[slot] = seq_ctr; tq_stop[slot] = 1'b0; tq_vld[slot] = 1'b1;
          push_result(KIND_ADDED, seq_ctr, tq_dl[slot]);
          seq_ctr++;
        end
        n = 1;
      end
      REQ_CANCEL: begin
        for (int i = 0; i < DEPTH; i++)
          if (tq_vld[i] && tq_seq[i] == cs && slot < 0) slot = i;
        if (slot < 0) push_result(KIND_MISS, cs, '0);
        else begin
          tq_stop[slot] = 1'b1;
          push_result(KIND_CANCEL, cs, tq_dl[slot]);
        end
        n = 1;
      end
      REQ_TICK: begin
        while (n < MAX_RESULTS) begin
          e = earliest_timer();
          if (e < 0 || tq_dl[e] > now) break;
          tq_vld[e] = 1'b0;
          if (!tq_stop[e]) begin
            push_result(KIND_FIRED, tq_seq[e], tq_dl[e]);
            n++;
          end
        end
        if (n == 0) begin
          push_result(KIND_NONE, '0, '0);
          n = 1;
        end
      end
      default: ;
    endcase
    if (n > 0) result_q[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_r, got;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        tq_vld[i] = 1'b0; tq_stop[i] = 1'b0;
      end
      seq_ctr = '0;
      fails = 0;
      result_q.delete();
    end else begin
      // compare before predicting: a word can never come out in its request's cycle
      if (rsp_w.valid && rsp_w.ready) begin
        got = '{rsp_w.result_kind, rsp_w.seq_num, rsp_w.deadline,
                rsp_w.next_deadline, rsp_w.armed, rsp_w.last};
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %p", got);
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
      if (req_w.valid && req_w.ready)
        predict_request(req_w.req_type, req_w.now_time, req_w.delay, req_w.cancel_seq);
    end
  end
endmodule

/* sim/deadline_timer_queue_core_tb.sv */
// deadline timer queue testbench top: clock, reset, request stimulus, result
// stalls and verdict; depends on dtq_pkg, dtq_if, dtq_checker and the core
module deadline_timer_queue_core_tb;
  import dtq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned TB    = 48;
  localparam int unsigned LIMIT = 600000;

  logic clk_i, rst_ni;
  int unsigned fails, pending;
  int unsigned cycle_cnt;
  bit stall_long;   // request side asks the receiver for one long hold-off
  bit hold_done;
  logic [31:0] seq_guess;  // rough count of adds, for cancel targets
  logic [TB-1:0] clock_ms; // advancing time base for well-formed traffic

  dtq_in_if  #(.TIME_BITS(TB)) req_w ();
  dtq_out_if #(.TIME_BITS(TB)) rsp_w ();

  deadline_timer_queue_core #(.DEPTH(DEPTH), .TIME_BITS(TB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_w.sink), .rsp_o(rsp_w.source)
  );

  dtq_checker #(.DEPTH(DEPTH), .TIME_BITS(TB)) chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_w(req_w.sink), .rsp_w(rsp_w.sink),
    .fail_cnt_o(fails), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on total cycles
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // offer one request word and hold it until taken, after a random gap;
  // valid stays high afterwards so a zero gap gives back to back words
  task automatic send_word(logic [1:0] rt, logic [TB-1:0] now, logic [31:0] dly,
                           logic [31:0] cs);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;   // stretches with no idling
    if (gap > 0) begin
      req_w.valid    <= 1'b0;
      req_w.req_type <= 2'($urandom());
      repeat (gap) @(negedge clk_i);
    end
    req_w.valid      <= 1'b1;
    req_w.req_type   <= rt;
    req_w.now_time   <= now;
    req_w.delay      <= dly;
    req_w.cancel_seq <= cs;
    do @(posedge clk_i); while (!req_w.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_w.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // result side: random stall per word, one long hold-off on request
  initial begin
    int w;
    rsp_w.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_long && !hold_done) begin
        rsp_w.ready <= 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_done = 1'b1;
      end
      w = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        rsp_w.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      rsp_w.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_w.valid);
    end
  end

  initial begin
    logic [1:0] rt;
    logic [31:0] dly, cs;
    logic [TB-1:0] now;
    int k;
    stall_long = 1'b0;
    seq_guess = '0;
    clock_ms = 48'd1000;
    req_w.valid = 1'b0;
    req_w.req_type = REQ_ADD;
    req_w.now_time = '0;
    req_w.delay = '0;
    req_w.cancel_seq = '0;
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty tick, empty cancel, extremes, overflow saturation
    send_word(REQ_TICK, '0, '0, '0);
    send_word(REQ_CANCEL, '1, '1, 32'hffff_ffff);
    send_word(REQ_ADD, '0, '0, '0);
    send_word(REQ_ADD, '1, 32'hffff_ffff, '0);
    send_word(REQ_ADD, 48'hffff_0000_0000, 32'hffff_ffff, '0);
    send_word(REQ_ADD, 48'd10, 32'd5, '0);
    send_word(REQ_ADD, 48'd10, 32'd5, '0);
    send_word(REQ_CANCEL, '0, '0, 32'd4);
    send_word(REQ_CANCEL, '0, '0, 32'd4);     // cancel of a stopped timer again
    send_word(2'd3, '1, '1, '1);              // unknown type, no word
    send_word(REQ_TICK, 48'd15, '0, '0);      // tie break, stopped one dropped
    send_word(REQ_CANCEL, '0, '0, 32'd4);     // already gone
    // fill until full, then tick everything out
    for (int i = 0; i < 15; i++) send_word(REQ_ADD, 48'd100, i % 3, '0);
    send_word(REQ_ADD, 48'd100, 32'd1, '0);
    send_word(REQ_TICK, 48'hffff_ffff_fffe, '0, '0);
    send_word(REQ_TICK, '1, '0, '0);
    wait_drained();
    seq_guess = 32'd20;

    // random traffic; a long result hold-off partway while requests keep coming
    for (int i = 0; i < 360; i++) begin
      if (i == 120) stall_long = 1'b1;
      if (i == 240) wait_drained();  // sender pause until all results are in
      k = $urandom_range(0, 99);
      if (k < 4) begin
        // noise: raw extremes
        rt = 2'($urandom());
        now = TB'({$urandom(), $urandom()});
        dly = $urandom();
        cs = $urandom();
      end else begin
        clock_ms += $urandom_range(0, 40);
        now = clock_ms;
        if (k < 50) begin
          rt = REQ_ADD;
          dly = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 120);
        end else if (k < 70) begin
          rt = REQ_CANCEL;
          cs = ($urandom_range(0, 4) == 0) ? $urandom()
               : seq_guess - $urandom_range(1, 20);
        end else rt = REQ_TICK;
        if ($urandom_range(0, 19) == 0) now = TB'({$urandom(), $urandom()});
      end
      if (rt == REQ_ADD) seq_guess++;
      send_word(rt, now, dly, cs);
    end

    wait_drained();
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* files.f */
design/dtq_pkg.sv
design/dtq_if.sv
design/dtq_datapath.sv
design/dtq_ctrl.sv
design/deadline_timer_queue_core.sv
sim/dtq_checker.sv
sim/deadline_timer_queue_core_tb.sv
